// ===== sv/rbfk_pkg.sv =====
// rbfk_pkg: shared types and constants of the squared-exponential kernel block
// no dependencies
`default_nettype none
package rbfk_pkg;
	typedef enum logic [2:0] {
		REG_POINT_DIM = 3'd0,
		REG_NEG_HALF  = 3'd1,
		REG_INV_LEN   = 3'd2,
		REG_SCALING   = 3'd3,
		REG_NOISE     = 3'd4,
		REG_JITTER    = 3'd5,
		REG_GRAD_EN   = 3'd6
	} reg_idx_t;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// reciprocals for the taylor divides, exact for any 32-bit dividend
	localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
	localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;

	// multiplier operand selects, issued in this order
	typedef enum logic [3:0] {
		MUL_X_LO   = 4'd0,
		MUL_X_HI   = 4'd1,
		MUL_T2     = 4'd2,
		MUL_T3     = 4'd3,
		MUL_T3_DIV = 4'd4,
		MUL_T4     = 4'd5,
		MUL_T5     = 4'd6,
		MUL_T5_DIV = 4'd7,
		MUL_SQ     = 4'd8,
		MUL_COV    = 4'd9,
		MUL_G1_LO  = 4'd10,
		MUL_G1_HI  = 4'd11,
		MUL_GR_LO  = 4'd12,
		MUL_GR_HI  = 4'd13
	} mul_op_t;

	typedef struct packed {
		logic    clr_acc;
		logic    acc_en;
		logic    mul_en;
		mul_op_t mul_op;
		logic    poly;
		logic    diag;
		logic    grad_zero;
	} dp_cmd_t;

	typedef struct packed {
		logic exp_zero;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/rbfk_if.sv =====
// rbfk_if: valid/ready channel interfaces for items, results and configuration writes
// no dependencies
`default_nettype none
interface rbfk_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  row_index;
	logic [7:0]  col_index;
	logic [2:0]  dim_index;
	logic signed [15:0] coord_value;
	modport source (output valid, cmd, row_index, col_index, dim_index, coord_value,
		input ready);
	modport sink (input valid, cmd, row_index, col_index, dim_index, coord_value,
		output ready);
endinterface

interface rbfk_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] cov_value;
	logic [31:0] grad_value;
	modport source (output valid, cov_value, grad_value, input ready);
	modport sink (input valid, cov_value, grad_value, output ready);
endinterface

interface rbfk_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/rbfk_datapath.sv =====
// rbfk_datapath: shared 32x32 multiplier, accumulator and exp datapath
// depends on rbfk_pkg
`default_nettype none
module rbfk_datapath (
	input  wire logic            clk,
	input  wire rbfk_pkg::dp_cmd_t cmd,
	input  wire logic signed [31:0] diff,
	input  wire logic [31:0]     neg_half,
	input  wire logic [31:0]     inv_len,
	input  wire logic [31:0]     scaling,
	input  wire logic [31:0]     noise,
	input  wire logic [31:0]     jitter,
	output rbfk_pkg::dp_stat_t   stat,
	output logic [31:0]          cov,
	output logic [31:0]          grad
);
	import rbfk_pkg::*;

	logic [63:0] d_q, x_q, y_q, p_q, t_q, r_q, g1_q, acc_q;
	logic [31:0] cov_q, grad_q;
	logic [31:0] mag;
	logic [63:0] sq;
	logic [31:0] ma, mb;
	logic [63:0] prod;
	logic [64:0] dsum;
	logic [63:0] hsum;

	assign mag = diff[31] ? 32'(-diff) : 32'(diff);
	assign sq = 64'(mag) * 64'(mag);
	assign dsum = {1'b0, d_q} + {1'b0, sq};

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.mul_op)
			MUL_X_LO:  begin ma = d_q[31:0];  mb = neg_half; end
			MUL_X_HI:  begin ma = d_q[63:32]; mb = neg_half; end
			MUL_T2:    begin ma = y_q[31:0];  mb = y_q[31:0]; end
			MUL_T3, MUL_T4, MUL_T5: begin ma = t_q[31:0]; mb = y_q[31:0]; end
			MUL_T3_DIV: begin ma = r_q[31:0]; mb = RECIP_3; end
			MUL_T5_DIV: begin ma = r_q[31:0]; mb = RECIP_5; end
			MUL_SQ:    begin ma = p_q[31:0];  mb = p_q[31:0]; end
			MUL_COV:   begin ma = scaling;    mb = p_q[31:0]; end
			MUL_G1_LO: begin ma = d_q[31:0];  mb = inv_len; end
			MUL_G1_HI: begin ma = d_q[63:32]; mb = inv_len; end
			MUL_GR_LO: begin ma = g1_q[31:0]; mb = cov_q; end
			MUL_GR_HI: begin ma = g1_q[63:32]; mb = cov_q; end
			default:   begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = 64'(ma) * 64'(mb);

	// x > 16.0 flushes exp to zero
	assign stat.exp_zero = (x_q > 64'(32'h0010_0000));

	// hi*b product: saturate if beyond 64 bits after the 2^32 weight
	function automatic logic [63:0] hi_add(input logic [63:0] lo, input logic [63:0] p,
		input int sh);
		logic [127:0] s;
		s = 128'(lo) + (128'(p) << (32 - sh));
		return (s[127:64] != '0) ? '1 : s[63:0];
	endfunction

	assign hsum = hi_add(acc_q, prod, 16);

	always_ff @(posedge clk) begin
		if (cmd.clr_acc) begin
			d_q <= '0;
		end else if (cmd.acc_en) begin
			d_q <= dsum[64] ? '1 : dsum[63:0];
		end
		if (cmd.mul_en) begin
			case (cmd.mul_op)
				MUL_X_LO: acc_q <= prod >> 16;
				MUL_X_HI: begin
					x_q <= hsum;
					y_q <= hsum << 7;
				end
				MUL_T2: begin
					t_q <= (prod >> 31) >> 1;
					p_q <= 64'h8000_0000 - y_q + ((prod >> 31) >> 1);
				end
				MUL_T3: r_q <= prod >> 31;
				MUL_T3_DIV: begin
					t_q <= prod >> 33;
					p_q <= p_q - (prod >> 33);
				end
				MUL_T4: begin
					t_q <= (prod >> 31) >> 2;
					p_q <= p_q + ((prod >> 31) >> 2);
				end
				MUL_T5: r_q <= prod >> 31;
				MUL_T5_DIV: p_q <= p_q - (prod >> 34);
				MUL_SQ: p_q <= (prod + 64'h4000_0000) >> 31;
				MUL_COV: begin
					cov_q <= (stat.exp_zero || prod[63]) ?
						((stat.exp_zero) ? 32'd0 : '1) : prod[62:31];
				end
				MUL_G1_LO: acc_q <= prod >> 16;
				MUL_G1_HI: g1_q <= hsum;
				MUL_GR_LO: acc_q <= prod >> 16;
				MUL_GR_HI: begin
					grad_q <= (hsum > 64'hFFFF_FFFF) ? '1 : hsum[31:0];
				end
				default: ;
			endcase
		end
		if (cmd.diag) begin
			cov_q <= ({1'b0, 1'b0, scaling} + {2'b0, noise} + {2'b0, jitter}) > 34'hFFFF_FFFF ?
				'1 : scaling + noise + jitter;
			grad_q <= '0;
		end
		if (cmd.grad_zero) grad_q <= '0;
	end

	assign cov = cov_q;
	assign grad = grad_q;
endmodule
`default_nettype wire

// ===== sv/rbfk_ctrl.sv =====
// rbfk_ctrl: sequencer for store writes, coordinate walk, exp and products
// depends on rbfk_pkg, rbfk_if
`default_nettype none
module rbfk_ctrl #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_DIM = 8,
	parameter int COORD_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	rbfk_in_if.sink              in_ch,
	rbfk_out_if.source           out_ch,
	input  wire logic [3:0]      point_dim,
	input  wire logic            grad_enable,
	input  wire rbfk_pkg::dp_stat_t stat,
	input  wire logic [31:0]     cov,
	input  wire logic [31:0]     grad,
	output rbfk_pkg::dp_cmd_t    cmd,
	output logic signed [31:0]   diff
);
	import rbfk_pkg::*;

	localparam int PW = $clog2(MAX_POINTS);
	localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW = PW + DW;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDA  = 8'b0000_0010,
		S_RDB  = 8'b0000_0100,
		S_ACC  = 8'b0000_1000,
		S_MUL  = 8'b0001_0000,
		S_DONE = 8'b0010_0000,
		S_OUT  = 8'b0100_0000,
		S_WAIT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [COORD_BITS-1:0] mem [MAX_POINTS*MAX_DIM];
	logic [COORD_BITS-1:0] rd_q, a_q;
	logic [7:0] row_q, col_q;
	logic [4:0] k_q, nd;
	logic [3:0] step_q;
	logic grad_q, rd_oob_q, a_oob_q;
	logic [7:0] rd_pt;
	logic [AW-1:0] rd_addr, wr_addr;
	logic wr_ok, res_q;
	logic [31:0] cov_o_q, grad_o_q;

	assign nd = (point_dim == 4'd0) ? 5'd1 :
		((32'(point_dim) > MAX_DIM) ? 5'(MAX_DIM) : {1'b0, point_dim});
	assign rd_pt = (state_q == S_RDA) ? row_q : col_q;
	assign rd_addr = AW'(32'(rd_pt) * MAX_DIM + 32'(k_q));
	assign wr_addr = AW'(32'(in_ch.row_index) * MAX_DIM + 32'(in_ch.dim_index));
	assign wr_ok = (32'(in_ch.row_index) < MAX_POINTS) && (32'(in_ch.dim_index) < MAX_DIM);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid && in_ch.cmd == CMD_WRITE && wr_ok)
			mem[wr_addr] <= COORD_BITS'(32'(signed'(in_ch.coord_value)));
		rd_q <= mem[rd_addr];
	end

	function automatic logic signed [32:0] sx(input logic [COORD_BITS-1:0] v, input logic z);
		return z ? 33'sd0 : 33'(signed'(v));
	endfunction

	always_ff @(posedge clk) begin
		if (state_q == S_RDB) begin
			a_q <= rd_q;
			a_oob_q <= rd_oob_q;
		end
		rd_oob_q <= 32'(rd_pt) >= MAX_POINTS;
	end
	assign diff = 32'(sx(a_q, a_oob_q) - sx(rd_q, rd_oob_q));

	// the output register lets the next item in while a result waits
	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = res_q;
	assign out_ch.cov_value = cov_o_q;
	assign out_ch.grad_value = grad_o_q;

	always_comb begin
		cmd = '0;
		cmd.mul_op = mul_op_t'(step_q);
		case (state_q)
			S_IDLE: cmd.clr_acc = 1'b1;
			S_ACC:  cmd.acc_en = 1'b1;
			S_MUL:  cmd.mul_en = !(step_q >= 4'(MUL_G1_LO) && !grad_q);
			S_DONE: cmd.grad_zero = !grad_q || stat.exp_zero;
			default: ;
		endcase
		if (state_q == S_IDLE && in_ch.valid && in_ch.cmd == CMD_QUERY &&
			in_ch.row_index == in_ch.col_index) cmd.diag = 1'b1;
	end

	logic [3:0] sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q <= 1'b0;
			k_q <= '0;
			step_q <= '0;
			sq_q <= '0;
			row_q <= '0;
			col_q <= '0;
			grad_q <= 1'b0;
			cov_o_q <= '0;
			grad_o_q <= '0;
		end else begin
			if (res_q && out_ch.ready) res_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_ch.valid) begin
					row_q <= in_ch.row_index;
					col_q <= in_ch.col_index;
					grad_q <= grad_enable;
					k_q <= '0;
					if (in_ch.cmd == CMD_QUERY) begin
						state_q <= (in_ch.row_index == in_ch.col_index) ? S_WAIT : S_RDA;
					end
				end
				S_WAIT: if (!res_q || out_ch.ready) begin
					cov_o_q <= cov;
					grad_o_q <= grad;
					res_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_ACC;
				S_ACC: begin
					if (k_q + 5'd1 >= nd) begin
						state_q <= S_MUL;
						step_q <= 4'(MUL_X_LO);
						sq_q <= '0;
					end else begin
						k_q <= k_q + 5'd1;
						state_q <= S_RDA;
					end
				end
				S_MUL: begin
					if (step_q == 4'(MUL_SQ) && sq_q != 4'd7) sq_q <= sq_q + 4'd1;
					else if (step_q == 4'(MUL_GR_HI)) state_q <= S_DONE;
					else step_q <= step_q + 4'd1;
				end
				S_DONE: state_q <= S_OUT;
				S_OUT: if (!res_q || out_ch.ready) begin
					cov_o_q <= cov;
					grad_o_q <= grad;
					res_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/rbf_kernel_matrix_entry.sv =====
// rbf_kernel_matrix_entry: top level, config registers, controller and datapath
// depends on rbfk_pkg, rbfk_if, rbfk_ctrl, rbfk_datapath
//
// channel | dir | fields
// in_ch   | in  | cmd, row_index, col_index, dim_index, coord_value
// out_ch  | out | cov_value, grad_value
// cfg     | in  | index, data
//
// a write item is stored in idle; a diagonal query passes S_WAIT to the output register
// an off-diagonal query reads the store twice per coordinate in use (RDA, RDB, ACC),
// then steps the single shared 32x32 multiplier through x, taylor with two
// reciprocal divides, 8 squares and the products
// one item at a time; a waiting result holds off only the finish of the next query
// reset restores register defaults; the store is undefined until written
`default_nettype none
module rbf_kernel_matrix_entry #(
	parameter int MAX_POINTS = 256,
	parameter int MAX_DIM = 8,
	parameter int COORD_BITS = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	rbfk_in_if.sink   in_ch,
	rbfk_out_if.source out_ch,
	rbfk_cfg_if.sink  cfg
);
	import rbfk_pkg::*;

	logic [3:0]  point_dim_q;
	logic [31:0] neg_half_q, inv_len_q, scaling_q, noise_q, jitter_q;
	logic        grad_en_q;
	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] cov, grad;
	logic signed [31:0] diff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_dim_q <= 4'd1;
			neg_half_q <= 32'h0000_8000;
			inv_len_q <= 32'h0001_0000;
			scaling_q <= 32'h0001_0000;
			noise_q <= '0;
			jitter_q <= '0;
			grad_en_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_POINT_DIM: point_dim_q <= cfg.data[3:0];
				REG_NEG_HALF:  neg_half_q <= cfg.data;
				REG_INV_LEN:   inv_len_q <= cfg.data;
				REG_SCALING:   scaling_q <= cfg.data;
				REG_NOISE:     noise_q <= cfg.data;
				REG_JITTER:    jitter_q <= cfg.data;
				REG_GRAD_EN:   grad_en_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	rbfk_ctrl #(
		.MAX_POINTS(MAX_POINTS), .MAX_DIM(MAX_DIM), .COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk, .arst_n, .in_ch, .out_ch,
		.point_dim(point_dim_q), .grad_enable(grad_en_q),
		.stat, .cov, .grad, .cmd, .diff
	);

	rbfk_datapath u_dp (
		.clk, .cmd, .diff,
		.neg_half(neg_half_q), .inv_len(inv_len_q), .scaling(scaling_q),
		.noise(noise_q), .jitter(jitter_q), .stat, .cov, .grad
	);
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// tb: self-checking testbench for rbf_kernel_matrix_entry
// depends on rbfk_pkg, rbfk_if and the rbf_kernel_matrix_entry top level
`default_nettype none
module tb;
	import rbfk_pkg::*;

	localparam int NPTS = 256;
	localparam int NDIM = 8;
	localparam int SETTLE = 3 * 15 + 40;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		logic [31:0] cov;
		logic [31:0] grad;
	} entry_t;

	logic clk;
	logic arst_n;

	rbfk_in_if  in_ch();
	rbfk_out_if out_ch();
	rbfk_cfg_if cfg();

	rbf_kernel_matrix_entry u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// shadow of the block's registers and point store
	logic [3:0]  sh_dim;
	logic [31:0] sh_neg_half;
	logic [31:0] sh_inv_len;
	logic [31:0] sh_scaling;
	logic [31:0] sh_noise;
	logic [31:0] sh_jitter;
	logic        sh_grad_en;
	logic signed [15:0] coords [NPTS][NDIM];
	bit written [NPTS][NDIM];

	entry_t pending_entries[$];
	int errors;
	int n_items, n_queries, n_writes, n_checked, n_nonzero_cov;
	longint cycles;
	int burst_left;
	int hold_cnt;
	int stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rbf_kernel_matrix_entry: mismatch");
			$finish;
		end
	end

	function automatic logic [63:0] mul_shr_sat(logic [63:0] a, logic [63:0] b, int sh,
			logic [63:0] cap);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> sh;
		return (p > {64'd0, cap}) ? cap : p[63:0];
	endfunction

	// exp(-x), x in Q16.16 at most 16.0, result in Q1.31
	function automatic logic [63:0] exp_neg_q31(logic [63:0] x);
		logic [63:0] y, t2, t3, t4, t5, p;
		y = x << 7;
		t2 = ((y * y) >> 31) / 2;
		t3 = ((t2 * y) >> 31) / 3;
		t4 = ((t3 * y) >> 31) / 4;
		t5 = ((t4 * y) >> 31) / 5;
		p = 64'h8000_0000 - y + t2 - t3 + t4 - t5;
		for (int i = 0; i < 8; i++)
			p = (p * p + 64'h4000_0000) >> 31;
		return p;
	endfunction

	function automatic int dims_in_use();
		if (sh_dim == 0)
			return 1;
		return (sh_dim > NDIM) ? NDIM : sh_dim;
	endfunction

	function automatic entry_t kernel_entry(logic [7:0] row, logic [7:0] col);
		entry_t r;
		logic [63:0] d, x, e, g1, sum;
		longint df;
		d = 0;
		r.grad = 0;
		if (row == col) begin
			sum = {32'd0, sh_scaling} + sh_noise + sh_jitter;
			r.cov = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		end else begin
			for (int k = 0; k < dims_in_use(); k++) begin
				df = longint'(coords[row][k]) - longint'(coords[col][k]);
				if (df < 0)
					df = -df;
				d = d + df * df;
			end
			x = mul_shr_sat(d, {32'd0, sh_neg_half}, 16, '1);
			e = (x > (64'd16 << 16)) ? 64'd0 : exp_neg_q31(x);
			r.cov = mul_shr_sat({32'd0, sh_scaling}, e, 31, 64'hFFFF_FFFF);
			if (sh_grad_en) begin
				g1 = mul_shr_sat(d, {32'd0, sh_inv_len}, 16, '1);
				r.grad = mul_shr_sat(g1, {32'd0, r.cov}, 16, 64'hFFFF_FFFF);
			end
		end
		return r;
	endfunction

	function automatic bit point_ready(int p);
		for (int k = 0; k < dims_in_use(); k++)
			if (!written[p][k])
				return 0;
		return 1;
	endfunction

	// result checker and receiver stall pattern
	always @(posedge clk) begin
		entry_t want;
		if (out_ch.valid && out_ch.ready) begin
			n_checked++;
			if (pending_entries.size() == 0) begin
				$error("result with no query outstanding: cov %h grad %h",
					out_ch.cov_value, out_ch.grad_value);
				errors++;
			end else begin
				want = pending_entries.pop_front();
				if (out_ch.cov_value !== want.cov) begin
					$error("cov_value expected %h actual %h", want.cov, out_ch.cov_value);
					errors++;
				end
				if (out_ch.grad_value !== want.grad) begin
					$error("grad_value expected %h actual %h", want.grad, out_ch.grad_value);
					errors++;
				end
			end
		end
		if (cycles % 256 == 0)
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 25;
				default: stall_pct = 70;
			endcase
		if (hold_cnt > 0) begin
			out_ch.ready <= 1'b0;
			hold_cnt--;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_item(logic c, logic [7:0] row, logic [7:0] col, logic [2:0] dim,
			logic signed [15:0] val, bit no_gap = 0);
		entry_t r;
		if (burst_left <= 0 && !no_gap) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 16);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.row_index <= row;
		in_ch.col_index <= col;
		in_ch.dim_index <= dim;
		in_ch.coord_value <= val;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		n_items++;
		if (c == CMD_WRITE) begin
			n_writes++;
			coords[row][dim] = val;
			written[row][dim] = 1;
		end else begin
			n_queries++;
			r = kernel_entry(row, col);
			if (r.cov != 0)
				n_nonzero_cov++;
			pending_entries = {pending_entries, r};
		end
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		wait (pending_entries.size() == 0);
		@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			REG_POINT_DIM: sh_dim = data[3:0];
			REG_NEG_HALF:  sh_neg_half = data;
			REG_INV_LEN:   sh_inv_len = data;
			REG_SCALING:   sh_scaling = data;
			REG_NOISE:     sh_noise = data;
			REG_JITTER:    sh_jitter = data;
			REG_GRAD_EN:   sh_grad_en = data[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $urandom_range(0, 1536) - 768;
	endfunction

	function automatic logic [7:0] pick_point();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 8'd240 + $urandom_range(0, 15);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// write all NDIM coordinates of one point, in use or not
	task automatic fill_point(logic [7:0] p);
		for (int k = 0; k < NDIM; k++)
			send_item(CMD_WRITE, p, $urandom, k[2:0], pick_coord());
	endtask

	// extremes of coordinates, diagonal, defaults, then gradient off with maximum noise
	task automatic test_directed();
		send_item(CMD_WRITE, 8'd0, 8'd0, 3'd0, -16'sd32768);
		send_item(CMD_WRITE, 8'd1, 8'hFF, 3'd0, 16'sd32767);
		send_item(CMD_WRITE, 8'd255, 8'd0, 3'd0, 16'sd0);
		send_item(CMD_WRITE, 8'd2, 8'd0, 3'd0, 16'sd256);
		send_item(CMD_WRITE, 8'd3, 8'd0, 3'd7, 16'sd1);
		send_item(CMD_WRITE, 8'd3, 8'd0, 3'd0, -16'sd1);
		send_item(CMD_QUERY, 8'd0, 8'd1, 3'd7, 16'sd0);
		send_item(CMD_QUERY, 8'd1, 8'd0, 3'd0, -16'sd1);
		send_item(CMD_QUERY, 8'd0, 8'd0, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd200, 8'd200, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd2, 8'd255, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd255, 8'd2, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd3, 8'd255, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd2, 8'd3, 3'd0, 16'sd0);
		wait_idle();
		write_reg(REG_GRAD_EN, 32'd0);
		write_reg(REG_NOISE, 32'hFFFF_FFFF);
		send_item(CMD_QUERY, 8'd2, 8'd255, 3'd0, 16'sd0);
		send_item(CMD_QUERY, 8'd7, 8'd7, 3'd0, 16'sd0);
		wait_idle();
	endtask

	// random traffic under one register setting
	task automatic test_random_phase(int n_total);
		int ready_pts[$];
		int a, b;
		write_reg(REG_POINT_DIM, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
			: $urandom_range(1, 3));
		write_reg(REG_NEG_HALF, pick_word(1, 32'h0000_8000));
		write_reg(REG_INV_LEN, pick_word(1, 32'h0004_0000));
		write_reg(REG_SCALING, pick_word(1, 32'h0010_0000));
		write_reg(REG_NOISE, pick_word(0, 32'h0001_0000));
		write_reg(REG_JITTER, pick_word(0, 32'h0000_1000));
		write_reg(REG_GRAD_EN, $urandom_range(0, 3) != 0);
		fill_point(pick_point());
		fill_point(pick_point());
		for (int i = 0; i < n_total; i++) begin
			ready_pts.delete();
			for (int p = 0; p < NPTS; p++)
				if (point_ready(p))
					ready_pts = {ready_pts, p};
			if (ready_pts.size() < 2 || $urandom_range(0, 99) < 30) begin
				send_item(CMD_WRITE, pick_point(), $urandom,
					($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 2),
					pick_coord());
			end else begin
				a = ready_pts[$urandom_range(0, ready_pts.size() - 1)];
				b = ($urandom_range(0, 7) == 0) ? a
					: ready_pts[$urandom_range(0, ready_pts.size() - 1)];
				send_item(CMD_QUERY, 8'(a), 8'(b), $urandom, $urandom);
			end
		end
		wait_idle();
	endtask

	// receiver holds off a long while and the sender keeps offering queries
	task automatic test_backpressure();
		// points 0 to 3 have their first coordinate written
		write_reg(REG_POINT_DIM, 32'd1);
		hold_cnt = 600;
		for (int i = 0; i < 30; i++)
			send_item(CMD_QUERY, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				$urandom, $urandom, 1);
		wait_idle();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 0;
		hold_cnt = 0;
		stall_pct = 0;
		n_items = 0;
		n_queries = 0;
		n_writes = 0;
		n_checked = 0;
		n_nonzero_cov = 0;
		sh_dim = 4'd1;
		sh_neg_half = 32'h8000;
		sh_inv_len = 32'h10000;
		sh_scaling = 32'h10000;
		sh_noise = 0;
		sh_jitter = 0;
		sh_grad_en = 1'b1;
		for (int p = 0; p < NPTS; p++)
			for (int k = 0; k < NDIM; k++) begin
				coords[p][k] = 0;
				written[p][k] = 0;
			end
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_WRITE;
		in_ch.row_index = 0;
		in_ch.col_index = 0;
		in_ch.dim_index = 0;
		in_ch.coord_value = 0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_POINT_DIM;
		cfg.data = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		// extreme dimension counts are written first; each random phase then sets its own
		write_reg(REG_POINT_DIM, 32'd8);
		test_random_phase(95);
		write_reg(REG_POINT_DIM, 32'd15);
		for (int ph = 0; ph < 7; ph++)
			test_random_phase(95);
		test_backpressure();

		wait_idle();
		$display("items %0d (writes %0d, queries %0d), results checked %0d, nonzero cov %0d",
			n_items, n_writes, n_queries, n_checked, n_nonzero_cov);
		$display("covered coordinate extremes, diagonal, gradient off, register extremes, stalls");
		if (errors == 0 && pending_entries.size() == 0) begin
			$display("rbf_kernel_matrix_entry: match");
		end else begin
			$display("rbf_kernel_matrix_entry: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
